### src/rtktq_pkg.sv
// Package for the rotation to key tap quantizer: field widths, codes, sequencer
// states and the request/response bundles of the shared divider.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package rtktq_pkg;

  // Field widths fixed by the item formats.
  localparam int MODE_W     = 2;
  localparam int SID_W      = 2;
  localparam int DEG_W      = 16;
  localparam int MICRO_W    = 21;
  localparam int POS_W      = 8;
  localparam int TPT_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Internal arithmetic widths.
  localparam int REST_DEG_W = 10;  // remainder of the detent division, |r| < 360
  localparam int WHOLE_W    = 18;  // remainder + delta + carry from the millionths
  localparam int FRAC_W     = 22;  // two millionth values summed
  localparam int DIVD_W     = 16;  // magnitude of the whole degrees
  localparam int DIVS_W     = 9;   // detent size in degrees

  localparam int DEG_PER_TURN  = 360;
  localparam int MICRO_PER_DEG = 1000000;

  localparam int SENSOR_COUNT_DEF = 4;
  localparam int MAX_TICKS_DEF    = 16;

  // Item modes; the fourth code behaves like a discard.
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISCARD = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_TURN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_POSITION    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_POSITION  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_NORM,
    ST_QUOT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [DIVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

### src/rtktq_if.sv
// Valid/ready channel interfaces for the rotation to key tap quantizer.
// Depends on rtktq_pkg for the field widths.
`timescale 1ns / 1ps

interface rtktq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [rtktq_pkg::MODE_W-1:0]   mode;
  logic        [rtktq_pkg::SID_W-1:0]    sensor_id;
  logic signed [rtktq_pkg::DEG_W-1:0]    delta_degrees;
  logic signed [rtktq_pkg::MICRO_W-1:0]  delta_micro;

  modport source (output valid, mode, sensor_id, delta_degrees, delta_micro, input ready);
  modport sink   (input valid, mode, sensor_id, delta_degrees, delta_micro, output ready);
endinterface

interface rtktq_out_if;
  logic                          valid;
  logic                          ready;
  logic [rtktq_pkg::POS_W-1:0]   key_position;
  logic                          last_press;

  modport source (output valid, key_position, last_press, input ready);
  modport sink   (input valid, key_position, last_press, output ready);
endinterface

### src/rotation_to_key_tap_quantizer_top.sv
// Top level of the rotation to key tap quantizer: sequencer, per-sensor state,
// configuration registers and press output. Depends on rtktq_pkg, rtktq_if, rtktq_div.
`timescale 1ns / 1ps

//  Channel   Direction  Beat carries                                  Handshake
//  in_s      in         mode, sensor_id, delta_degrees, delta_micro   valid/ready
//  out_s     out        key_position, last_press                      valid/ready
//  cfg       in         cfg_idx_i, cfg_data_i                         cfg_we_i
//
// A sample beat with nonzero degrees makes two passes through the shared divider: the first
// finds the detent size, which is latched; the millionths carry is then applied in steps of
// 1000000 and the second pass divides the whole degrees by the detent. A trigger beat with n
// pending ticks emits one press per cycle while the sink takes them; every other beat is done
// in the cycle it is accepted. Reset clears all sensor state and loads the register defaults;
// no clearing pass. The input is held off while a beat is in progress, and a stalled output
// holds its beat and the press run with it.

module rotation_to_key_tap_quantizer_top #(
  parameter int SENSOR_COUNT = rtktq_pkg::SENSOR_COUNT_DEF,
  parameter int MAX_TICKS    = rtktq_pkg::MAX_TICKS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rtktq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rtktq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  rtktq_in_if.sink                            in_s,
  rtktq_out_if.source                         out_s
);

  localparam int IDX_W      = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int CNT_W      = $clog2(MAX_TICKS + 1);
  localparam int PEND_W     = CNT_W + 1;
  localparam int WHOLE_W    = rtktq_pkg::WHOLE_W;
  localparam int FRAC_W     = rtktq_pkg::FRAC_W;
  localparam int REST_DEG_W = rtktq_pkg::REST_DEG_W;
  localparam int MICRO_W    = rtktq_pkg::MICRO_W;
  localparam int DIVD_W     = rtktq_pkg::DIVD_W;
  localparam int DIVS_W     = rtktq_pkg::DIVS_W;
  localparam int POS_W      = rtktq_pkg::POS_W;
  localparam int TPT_W      = rtktq_pkg::TPT_W;

  localparam logic signed [FRAC_W-1:0]  MICRO      = FRAC_W'(rtktq_pkg::MICRO_PER_DEG);
  localparam logic signed [MICRO_W-1:0] MAX_MICRO  = MICRO_W'(MAX_TICKS);
  localparam logic signed [PEND_W-1:0]  MAX_PEND   = PEND_W'(MAX_TICKS);
  localparam logic        [DIVD_W-1:0]  MAX_QUOT   = DIVD_W'(MAX_TICKS);
  localparam logic        [TPT_W-1:0]   TURN_DEG   = TPT_W'(rtktq_pkg::DEG_PER_TURN);

  rtktq_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [TPT_W-1:0] tpt_q;
  logic [POS_W-1:0] up_q;
  logic [POS_W-1:0] down_q;

  // Per-sensor state.
  logic signed [REST_DEG_W-1:0] rest_deg_q   [SENSOR_COUNT];
  logic signed [MICRO_W-1:0]    rest_micro_q [SENSOR_COUNT];
  logic signed [PEND_W-1:0]     pend_q       [SENSOR_COUNT];

  // Working registers of the sample sequence.
  logic [IDX_W-1:0]          idx_q;
  logic signed [WHOLE_W-1:0] whole_q, whole_d;
  logic signed [FRAC_W-1:0]  frac_q, frac_d;
  logic [DIVS_W-1:0]         step_q;

  // Press emission.
  logic [CNT_W-1:0] cnt_q;
  logic [POS_W-1:0] pos_q;
  logic             out_valid_q;
  logic [POS_W-1:0] out_key_q;
  logic             out_last_q;

  rtktq_pkg::div_req_t div_req;
  rtktq_pkg::div_rsp_t div_rsp;

  logic                    in_acc;
  logic [IDX_W-1:0]        in_idx;
  logic                    id_ok;
  logic                    deg_zero;
  logic signed [PEND_W-1:0] legacy_ticks;
  logic signed [PEND_W-1:0] cur_pend;
  logic [CNT_W-1:0]        cur_mag;
  logic [TPT_W-1:0]        tpt_eff;
  logic                    frac_hi;
  logic                    frac_lo;
  logic                    whole_neg;
  logic [WHOLE_W-1:0]      whole_abs;
  logic [DIVD_W-1:0]       quot_clamped;
  logic signed [PEND_W-1:0] quot_ticks;
  logic signed [REST_DEG_W-1:0] rem_signed;
  logic                    emit_load;

  rtktq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Decode of the incoming beat.
  assign in_acc   = in_s.valid && in_s.ready;
  assign in_idx   = IDX_W'(in_s.sensor_id);
  assign id_ok    = int'(in_s.sensor_id) < SENSOR_COUNT;
  assign deg_zero = in_s.delta_degrees == '0;
  assign cur_pend = pend_q[in_idx];

  // On the legacy path the raw value is the tick count, clamped.
  always_comb begin
    if (in_s.delta_micro > MAX_MICRO) begin
      legacy_ticks = MAX_PEND;
    end else if (in_s.delta_micro < -MAX_MICRO) begin
      legacy_ticks = -MAX_PEND;
    end else begin
      legacy_ticks = PEND_W'(in_s.delta_micro);
    end
  end

  always_comb begin
    if (cur_pend[PEND_W-1]) begin
      cur_mag = CNT_W'(-cur_pend);
    end else begin
      cur_mag = CNT_W'(cur_pend);
    end
  end

  // An unusable ticks_per_turn is pinned into 1..360 so the detent is never zero.
  always_comb begin
    if (tpt_q == '0) begin
      tpt_eff = TPT_W'(1);
    end else if (tpt_q > TURN_DEG) begin
      tpt_eff = TURN_DEG;
    end else begin
      tpt_eff = tpt_q;
    end
  end

  // Millionths carry: one step of 1000000 toward zero per cycle.
  assign frac_hi = frac_q >= MICRO;
  assign frac_lo = frac_q <= -MICRO;

  // Signed division is done on magnitudes; quotient and remainder take the
  // sign of the whole degrees, which is truncation toward zero.
  assign whole_neg = whole_q[WHOLE_W-1];
  assign whole_abs = whole_neg ? WHOLE_W'(-whole_q) : WHOLE_W'(whole_q);
  assign quot_clamped = (div_rsp.quotient > MAX_QUOT) ? MAX_QUOT : div_rsp.quotient;
  assign quot_ticks = whole_neg ? -PEND_W'(quot_clamped) : PEND_W'(quot_clamped);
  assign rem_signed = whole_neg ? -REST_DEG_W'(div_rsp.remainder)
                                :  REST_DEG_W'(div_rsp.remainder);

  assign whole_d = WHOLE_W'(rest_deg_q[in_idx]) + WHOLE_W'(in_s.delta_degrees);
  assign frac_d  = FRAC_W'(rest_micro_q[in_idx]) + FRAC_W'(in_s.delta_micro);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rtktq_pkg::ST_IDLE: begin
        if (in_acc && id_ok) begin
          if (in_s.mode == rtktq_pkg::MODE_SAMPLE && !deg_zero) begin
            state_d = rtktq_pkg::ST_STEP;
          end else if (in_s.mode == rtktq_pkg::MODE_TRIGGER && cur_mag != '0) begin
            state_d = rtktq_pkg::ST_EMIT;
          end
        end
      end
      rtktq_pkg::ST_STEP: begin
        if (div_rsp.done) begin
          state_d = rtktq_pkg::ST_NORM;
        end
      end
      rtktq_pkg::ST_NORM: begin
        if (!frac_hi && !frac_lo) begin
          state_d = rtktq_pkg::ST_QUOT;
        end
      end
      rtktq_pkg::ST_QUOT: begin
        if (div_rsp.done) begin
          state_d = rtktq_pkg::ST_IDLE;
        end
      end
      rtktq_pkg::ST_EMIT: begin
        if (emit_load && cnt_q == CNT_W'(1)) begin
          state_d = rtktq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rtktq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_s.ready       = 1'b0;
    emit_load        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIVD_W'(rtktq_pkg::DEG_PER_TURN);
    div_req.divisor  = DIVS_W'(tpt_eff);
    case (state_q)
      rtktq_pkg::ST_IDLE: begin
        in_s.ready    = 1'b1;
        div_req.start = in_acc && id_ok && in_s.mode == rtktq_pkg::MODE_SAMPLE && !deg_zero;
      end
      rtktq_pkg::ST_NORM: begin
        div_req.start    = !frac_hi && !frac_lo;
        div_req.dividend = whole_abs[DIVD_W-1:0];
        div_req.divisor  = step_q;
      end
      rtktq_pkg::ST_EMIT: begin
        emit_load = !out_valid_q || out_s.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtktq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpt_q  <= TPT_W'(20);
      up_q   <= POS_W'(0);
      down_q <= POS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rtktq_pkg::CFG_TICKS_PER_TURN: tpt_q  <= cfg_data_i;
        rtktq_pkg::CFG_UP_POSITION:    up_q   <= cfg_data_i[POS_W-1:0];
        rtktq_pkg::CFG_DOWN_POSITION:  down_q <= cfg_data_i[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Per-sensor state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        rest_deg_q[i]   <= '0;
        rest_micro_q[i] <= '0;
        pend_q[i]       <= '0;
      end
    end else begin
      if (state_q == rtktq_pkg::ST_IDLE && in_acc && id_ok) begin
        if (in_s.mode == rtktq_pkg::MODE_SAMPLE) begin
          if (deg_zero) begin
            pend_q[in_idx] <= legacy_ticks;
          end
        end else if (in_s.mode != rtktq_pkg::MODE_TRIGGER) begin
          pend_q[in_idx] <= '0;
        end
      end
      if (state_q == rtktq_pkg::ST_QUOT && div_rsp.done) begin
        rest_deg_q[idx_q]   <= rem_signed;
        rest_micro_q[idx_q] <= MICRO_W'(frac_q);
        pend_q[idx_q]       <= quot_ticks;
      end
    end
  end

  // Working registers of the sample sequence and of the press run.
  always_ff @(posedge clk_i) begin
    if (state_q == rtktq_pkg::ST_IDLE && in_acc) begin
      idx_q   <= in_idx;
      whole_q <= whole_d;
      frac_q  <= frac_d;
      cnt_q   <= cur_mag;
      pos_q   <= cur_pend[PEND_W-1] ? down_q : up_q;
    end
    if (state_q == rtktq_pkg::ST_STEP && div_rsp.done) begin
      step_q <= div_rsp.quotient[DIVS_W-1:0];
    end
    if (state_q == rtktq_pkg::ST_NORM) begin
      if (frac_hi) begin
        frac_q  <= frac_q - MICRO;
        whole_q <= whole_q + WHOLE_W'(1);
      end else if (frac_lo) begin
        frac_q  <= frac_q + MICRO;
        whole_q <= whole_q - WHOLE_W'(1);
      end
    end
    if (emit_load) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Output register: one press per cycle, held while the sink stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_key_q  <= pos_q;
      out_last_q <= cnt_q == CNT_W'(1);
    end
  end

  assign out_s.valid        = out_valid_q;
  assign out_s.key_position = out_key_q;
  assign out_s.last_press   = out_last_q;

endmodule

### src/rtktq_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on rtktq_pkg for the operand widths and the request/response structs.
`timescale 1ns / 1ps

module rtktq_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtktq_pkg::div_req_t req_i,
  output rtktq_pkg::div_rsp_t rsp_o
);

  localparam int DIVD_W = rtktq_pkg::DIVD_W;
  localparam int DIVS_W = rtktq_pkg::DIVS_W;
  localparam int CNT_W  = $clog2(DIVD_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVS_W-1:0] divisor_q;
  logic [DIVS_W-1:0] rem_q;
  logic [DIVD_W-1:0] quo_q;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              fits;

  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      divisor_q <= req_i.divisor;
      rem_q     <= '0;
      quo_q     <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], fits};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

### src/rtktq_chk.sv
// Port-level checker for the rotation to key tap quantizer, bound to the top level.
// Depends on rtktq_pkg for the mode codes.
`timescale 1ns / 1ps

module rtktq_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [rtktq_pkg::MODE_W-1:0]      in_mode,
  input logic [rtktq_pkg::DEG_W-1:0]       in_deg,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rtktq_pkg::POS_W-1:0]       out_key,
  input logic                              out_last
);

  // A stalled press keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_last))
    else $error("stalled press changed");

  // A new press only appears while the input side is held off.
  a_press_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("press appeared while idle");

  // While a press that is not the last one is shown, the run is still going.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of a press run");

  // Discards and legacy samples finish in the cycle they arrive.
  a_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_mode != rtktq_pkg::MODE_TRIGGER &&
    (in_mode != rtktq_pkg::MODE_SAMPLE || in_deg == '0) |=> in_ready)
    else $error("single-cycle beat held the input");

endmodule

bind rotation_to_key_tap_quantizer_top rtktq_chk u_rtktq_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .in_mode   (in_s.mode),
  .in_deg    (in_s.delta_degrees),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_key   (out_s.key_position),
  .out_last  (out_s.last_press)
);

### dv/rotation_to_key_tap_quantizer_top_tb.sv
// Self-checking testbench for the rotation to key tap quantizer: directed, back-pressure
// and random encoder beats, scored against an in-bench model of the detent accumulator.
// Depends on rtktq_pkg, rtktq_if and the RTL under src.
`timescale 1ns / 1ps

module rotation_to_key_tap_quantizer_top_tb;

  localparam int MODE_W        = rtktq_pkg::MODE_W;
  localparam int SID_W         = rtktq_pkg::SID_W;
  localparam int DEG_W         = rtktq_pkg::DEG_W;
  localparam int MICRO_W       = rtktq_pkg::MICRO_W;
  localparam int POS_W         = rtktq_pkg::POS_W;
  localparam int CFG_IDX_W     = rtktq_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = rtktq_pkg::CFG_DATA_W;
  localparam int DEG_PER_TURN  = rtktq_pkg::DEG_PER_TURN;
  localparam int MICRO_PER_DEG = rtktq_pkg::MICRO_PER_DEG;

  localparam int SENSORS         = rtktq_pkg::SENSOR_COUNT_DEF;
  localparam int TICK_LIMIT      = rtktq_pkg::MAX_TICKS_DEF;
  // A sample beat keeps the block busy through two divider passes and emits nothing, so an
  // empty press queue alone does not prove the block is idle.
  localparam int SETTLE_CYCLES   = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int REPORT_LIMIT    = 10;
  localparam int LIMIT_NS        = 5_000_000;

  // The fourth mode code has no name in the package; the block treats it as a discard.
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] key_position;
    logic             last_press;
  } press_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  rtktq_in_if  in_if ();
  rtktq_out_if out_if ();

  rotation_to_key_tap_quantizer_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_if),
    .out_s      (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block: per-sensor remainders and pending ticks, plus the registers.
  int          rest_whole   [SENSORS];
  int          rest_frac    [SENSORS];
  int          tick_pending [SENSORS];
  int unsigned ticks_per_turn_q;
  int unsigned up_pos_q;
  int unsigned down_pos_q;

  // Presses predicted from accepted trigger beats, oldest first.
  press_t expected_presses [$];

  bit idling_on;
  int hold_left;
  int beats_sent;
  int presses_seen;
  int settings_used;
  int fail_count;

  function automatic void flag_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  function automatic int saturate_ticks(int t);
    if (t > TICK_LIMIT) return TICK_LIMIT;
    if (t < -TICK_LIMIT) return -TICK_LIMIT;
    return t;
  endfunction

  // Updates the shadow state for one accepted beat and queues the presses it causes.
  // SystemVerilog integer division truncates toward zero and the remainder takes the
  // sign of the dividend, which is exactly the arithmetic the block implements.
  function automatic void predict_presses(logic [MODE_W-1:0] mode, logic [SID_W-1:0] sid,
                                          logic signed [DEG_W-1:0] deg,
                                          logic signed [MICRO_W-1:0] micro);
    int               d;
    int               m;
    int               tpt;
    int               detent;
    int               whole;
    int               frac;
    int               n;
    int               k;
    logic [POS_W-1:0] pos;
    press_t           p;
    d = deg;
    m = micro;
    if (int'(sid) >= SENSORS) return;
    case (mode)
      rtktq_pkg::MODE_SAMPLE: begin
        if (d == 0) begin
          // Legacy path: the millionths field is the tick count, remainders untouched.
          tick_pending[sid] = saturate_ticks(m);
        end else begin
          tpt = ticks_per_turn_q;
          if (tpt == 0) tpt = 1;
          if (tpt > DEG_PER_TURN) tpt = DEG_PER_TURN;
          detent = DEG_PER_TURN / tpt;
          whole  = rest_whole[sid] + d;
          frac   = rest_frac[sid] + m;
          whole += frac / MICRO_PER_DEG;
          frac   = frac % MICRO_PER_DEG;
          tick_pending[sid] = saturate_ticks(whole / detent);
          rest_whole[sid]   = whole % detent;
          rest_frac[sid]    = frac;
        end
      end
      rtktq_pkg::MODE_TRIGGER: begin
        // Ticks stay pending, so a repeated trigger repeats the presses.
        n   = tick_pending[sid];
        pos = (n > 0) ? up_pos_q[POS_W-1:0] : down_pos_q[POS_W-1:0];
        if (n < 0) n = -n;
        for (k = 0; k < n; k++) begin
          p.key_position = pos;
          p.last_press   = (k == n - 1);
          expected_presses.push_back(p);
        end
      end
      default: begin
        // Discard, and the reserved code behaves the same.
        tick_pending[sid] = 0;
      end
    endcase
  endfunction

  // Offers one beat on the input channel. Entered and left just after a falling edge;
  // valid is left high so that back-to-back beats never drop it for a cycle.
  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [SID_W-1:0] sid,
                           input int deg, input int micro);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.mode          <= mode;
    in_if.sensor_id     <= sid;
    in_if.delta_degrees <= deg[DEG_W-1:0];
    in_if.delta_micro   <= micro[MICRO_W-1:0];
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_presses(mode, sid, deg[DEG_W-1:0], micro[MICRO_W-1:0]);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering beats and waits until every press has come and the block has had
  // time to finish a sample that produces none.
  task automatic wait_for_quiet();
    in_if.valid <= 1'b0;
    while (expected_presses.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes all three registers on consecutive cycles while the block is idle.
  task automatic program_registers(input int unsigned tpt, input int unsigned up,
                                   input int unsigned down);
    wait_for_quiet();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= rtktq_pkg::CFG_TICKS_PER_TURN;
    cfg_data_i <= tpt[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_idx_i  <= rtktq_pkg::CFG_UP_POSITION;
    cfg_data_i <= up[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_idx_i  <= rtktq_pkg::CFG_DOWN_POSITION;
    cfg_data_i <= down[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    // The position registers keep only their low eight bits of the write data.
    ticks_per_turn_q = tpt & 32'h1FF;
    up_pos_q         = up & 32'hFF;
    down_pos_q       = down & 32'hFF;
    settings_used++;
  endtask

  // Register values out of reset: twenty detents per turn, up on 0, down on 1.
  task automatic test_reset_defaults();
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd0, 0, 5);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd0, 0, 0);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd1, 0, -3);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd1, 0, 0);
    // A second trigger on the same sensor must repeat the three presses.
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd1, 0, 0);
    // 37 degrees over an 18 degree detent: two ticks, one degree kept.
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd2, 37, 0);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd2, 0, 0);
    send_beat(rtktq_pkg::MODE_DISCARD, 2'd1, 0, 0);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd1, 0, 0);
    // Zero pending ticks give no press at all.
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd3, 0, 0);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd3, 0, 0);
  endtask

  // Field extremes, clamping, carries, unreconciled signs and bad detent counts.
  task automatic test_field_extremes();
    program_registers(DEG_PER_TURN, 255, 0);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd0, 32767, 999999);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd0, 0, 0);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd1, -32768, -999999);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd1, 0, 0);
    // A sample overwrites the pending ticks rather than adding to them.
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd2, 0, 999999);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd2, 0, -999999);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd2, 0, 0);

    // One detent per full turn; the carry from the millionths completes the turn.
    program_registers(1, 0, 255);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd0, 359, 1);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd0, 0, 0);
    // Positive degrees with negative millionths are kept as they are.
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd3, 1, -999999);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd3, -1, -1);

    // Zero detents per turn acts as one.
    program_registers(0, 17, 200);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd0, -720, 0);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd0, 0, 0);

    // Above 360 acts as 360; bit 8 of the position writes is dropped.
    program_registers(9'h1FF, 9'h1AA, 9'h155);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd1, 3, 0);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd1, 0, 0);
    send_beat(MODE_RESERVED, 2'd1, 0, 0);
    send_beat(rtktq_pkg::MODE_TRIGGER, 2'd1, 0, 0);
  endtask

  // The press sink holds off for a long stretch while full-length triggers keep coming,
  // so the block must stall its input and hold its output beat.
  task automatic test_output_backpressure();
    int i;
    program_registers(36, 7, 8);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd0, 0, TICK_LIMIT);
    send_beat(rtktq_pkg::MODE_SAMPLE, 2'd1, 0, -TICK_LIMIT);
    hold_left = HOLD_OFF_CYCLES;
    for (i = 0; i < 6; i++) begin
      send_beat(rtktq_pkg::MODE_TRIGGER, i[SID_W-1:0] & 2'd1, 0, 0);
    end
  endtask

  // Random traffic in four phases with a fresh register setting each; the last phase
  // runs without any idling on either side.
  task automatic test_random_traffic(input int beats);
    int               phase;
    int               target;
    int unsigned      tpt;
    logic [SID_W-1:0] sid;
    int               deg;
    int               micro;
    for (phase = 0; phase < 4; phase++) begin
      case ($urandom_range(0, 5))
        0:       tpt = 1;
        1:       tpt = DEG_PER_TURN;
        2:       tpt = 0;
        3:       tpt = $urandom_range(DEG_PER_TURN + 1, 511);
        default: tpt = $urandom_range(1, DEG_PER_TURN);
      endcase
      program_registers(tpt, $urandom_range(0, 511), $urandom_range(0, 511));
      if (phase == 3) idling_on = 1'b0;
      target = beats_sent + beats / 4;
      while (beats_sent < target) begin
        sid   = SID_W'($urandom_range(0, SENSORS - 1));
        // Mostly moderate turns so the ticks vary; sometimes the full field range.
        deg   = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                              : int'($urandom_range(0, 120)) - 60;
        micro = int'($urandom_range(0, 1999998)) - 999999;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            send_beat(rtktq_pkg::MODE_SAMPLE, sid, deg, micro);
            send_beat(rtktq_pkg::MODE_TRIGGER, sid,
                      int'($urandom_range(0, 65535)) - 32768, micro);
          end
          6: begin
            micro = ($urandom_range(0, 2) == 0) ? micro : int'($urandom_range(0, 40)) - 20;
            send_beat(rtktq_pkg::MODE_SAMPLE, sid, 0, micro);
            send_beat(rtktq_pkg::MODE_TRIGGER, sid, 0, micro);
          end
          7: send_beat(rtktq_pkg::MODE_DISCARD, sid, deg, micro);
          8: send_beat(MODE_RESERVED, sid, deg, micro);
          default: begin
            send_beat($urandom_range(0, 1) ? rtktq_pkg::MODE_SAMPLE : rtktq_pkg::MODE_TRIGGER,
                      sid, deg, micro);
          end
        endcase
      end
    end
  endtask

  // Press sink: random stall bursts, plus the long hold-off counted down here.
  initial begin : press_sink
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall = $urandom_range(1, 17) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Every accepted press beat is scored against the oldest prediction.
  always @(posedge clk_i) begin : press_check
    press_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      presses_seen++;
      if (expected_presses.size() == 0) begin
        flag_failure($sformatf("unexpected press: expected none, got pos %0d last %0b",
                               out_if.key_position, out_if.last_press));
      end else begin
        want = expected_presses.pop_front();
        if (out_if.key_position !== want.key_position ||
            out_if.last_press !== want.last_press) begin
          flag_failure($sformatf("press mismatch: expected pos %0d last %0b, got %0d %0b",
                                 want.key_position, want.last_press,
                                 out_if.key_position, out_if.last_press));
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : sequencer
    int i;
    idling_on           = 1'b1;
    hold_left           = 0;
    beats_sent          = 0;
    presses_seen        = 0;
    settings_used       = 1;
    fail_count          = 0;
    ticks_per_turn_q    = 20;
    up_pos_q            = 0;
    down_pos_q          = 1;
    for (i = 0; i < SENSORS; i++) begin
      rest_whole[i]   = 0;
      rest_frac[i]    = 0;
      tick_pending[i] = 0;
    end
    in_if.valid         = 1'b0;
    in_if.mode          = rtktq_pkg::MODE_SAMPLE;
    in_if.sensor_id     = '0;
    in_if.delta_degrees = '0;
    in_if.delta_micro   = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_defaults();
    test_field_extremes();
    test_output_backpressure();
    test_random_traffic(124);
    wait_for_quiet();

    $display("Summary: %0d encoder beats sent, %0d press beats scored, %0d register settings.",
             beats_sent, presses_seen, settings_used);
    $display("Summary: %0d failures, including sink hold-off and runs without idling.",
             fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
